### src/mbr_pkg.sv
package mbr_pkg;

   // Macroblock layout in bytes
   localparam int MB_BYTES   = 384;
   localparam int LUMA_BYTES = 256;

   // Field widths
   localparam int MB_DIM_W    = 6;   // macroblock column / row / size
   localparam int BYTE_IDX_W  = 9;
   localparam int PIX_W       = 10;  // line, pitch and offset in samples
   localparam int ADDR_W      = 19;
   localparam int SAMPLE_W    = 8;
   localparam int CSR_INDEX_W = 4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_MBS  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_MBS = 4'd1;

   // Register reset values
   localparam logic [MB_DIM_W-1:0] WIDTH_MBS_RESET  = 6'd45;
   localparam logic [MB_DIM_W-1:0] HEIGHT_MBS_RESET = 6'd36;

   typedef enum logic [1:0] {
      PLANE_Y = 2'd0,
      PLANE_U = 2'd1,
      PLANE_V = 2'd2
   } plane_type;

   // Current sample position, split for the address multiply
   typedef struct packed {
      plane_type         plane;
      logic [PIX_W-1:0]  line;       // sample row within the plane
      logic [PIX_W-1:0]  pitch;      // samples per row of the plane
      logic [PIX_W-1:0]  offset;     // sample column within the plane
      logic              mb_last;
      logic              frame_last;
   } pos_type;

   typedef struct packed {
      pos_type              pos;
      logic [SAMPLE_W-1:0]  sample;
   } stage_type;

   typedef struct packed {
      plane_type            plane;
      logic [ADDR_W-1:0]    address;
      logic [SAMPLE_W-1:0]  sample;
      logic                 mb_last;
      logic                 frame_last;
   } result_type;

endpackage

### src/mbr_cursor.sv
module mbr_cursor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [mbr_pkg::MB_DIM_W-1:0]  width_eff,
   input  logic [mbr_pkg::MB_DIM_W-1:0]  height_eff,
   output mbr_pkg::pos_type              pos
);
   import mbr_pkg::*;

   localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(MB_BYTES - 1);

   logic [BYTE_IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [MB_DIM_W-1:0]   mb_column_ff, mb_column_in;
   logic [MB_DIM_W-1:0]   mb_row_ff, mb_row_in;
   logic [MB_DIM_W:0]     column_inc, row_inc;
   logic                  mb_end, column_wrap, row_wrap;
   logic [5:0]            chroma_k;

   assign mb_end      = (byte_index_ff == LAST_BYTE);
   assign column_inc  = {1'b0, mb_column_ff} + 1'b1;
   assign row_inc     = {1'b0, mb_row_ff} + 1'b1;
   assign column_wrap = (column_inc >= {1'b0, width_eff});
   assign row_wrap    = (row_inc >= {1'b0, height_eff});

   // Position advance
   always_comb begin
      byte_index_in = byte_index_ff;
      mb_column_in  = mb_column_ff;
      mb_row_in     = mb_row_ff;
      if (step) begin
         if (mb_end) begin
            byte_index_in = '0;
            if (column_wrap) begin
               mb_column_in = '0;
               mb_row_in    = row_wrap ? '0 : row_inc[MB_DIM_W-1:0];
            end else begin
               mb_column_in = column_inc[MB_DIM_W-1:0];
            end
         end else begin
            byte_index_in = byte_index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         mb_column_ff  <= '0;
         mb_row_ff     <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
         mb_column_ff  <= mb_column_in;
         mb_row_ff     <= mb_row_in;
      end
   end

   // Plane decode: bit 8 marks chroma, bit 6 then picks Cr over Cb
   assign chroma_k = byte_index_ff[5:0];

   always_comb begin
      if (!byte_index_ff[8]) begin
         pos.plane  = PLANE_Y;
         pos.line   = {mb_row_ff, byte_index_ff[7:4]};
         pos.pitch  = {width_eff, 4'b0000};
         pos.offset = {mb_column_ff, byte_index_ff[3:0]};
      end else begin
         pos.plane  = byte_index_ff[6] ? PLANE_V : PLANE_U;
         pos.line   = {1'b0, mb_row_ff, chroma_k[5:3]};
         pos.pitch  = {1'b0, width_eff, 3'b000};
         pos.offset = {1'b0, mb_column_ff, chroma_k[2:0]};
      end
      pos.mb_last    = mb_end;
      pos.frame_last = mb_end && column_wrap && row_wrap;
   end

endmodule

### src/mbr_addr_stage.sv
module mbr_addr_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mbr_pkg::stage_type    in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mbr_pkg::result_type   out_word
);
   import mbr_pkg::*;

   logic                  valid_ff, valid_in;
   result_type            result_ff, result_in;
   logic [2*PIX_W-1:0]    product;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // line * pitch + offset, kept modulo the address width
   assign product = in_word.pos.line * in_word.pos.pitch;

   always_comb begin
      result_in.plane      = in_word.pos.plane;
      result_in.address    = product[ADDR_W-1:0] + ADDR_W'(in_word.pos.offset);
      result_in.sample     = in_word.sample;
      result_in.mb_last    = in_word.pos.mb_last;
      result_in.frame_last = in_word.pos.frame_last;
      valid_in             = load || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = result_ff;

endmodule

### src/macroblock_raster_address_gen.sv
// Channel  Ports         Direction  Word contents (low bit first)
// req      req_t*        in         tdata: pixel_value[7:0]
// rsp      rsp_t*        out        tdata: address[18:0], sample[26:19], zero[31:27]
//                                   tuser: plane[1:0], mb_last[2]; tlast: frame_last
// csr      csr_*         in         index: 0 width_mbs, 1 height_mbs; data 6 bits
//
// One word per clock sustained while rsp is ready. The path from req to rsp is a
// cursor/decode stage register, then a 10x10 multiply-add into the result register.
// Each stage has its own valid bit, so req stays ready while one result waits; req
// stalls only when both stages hold words and rsp is not ready.
// Reset clears the cursor, both valid bits and loads the size registers with
// 45 x 36 macroblocks. csr is always ready.
module macroblock_raster_address_gen #(
   parameter int MAX_FRAME_WIDTH  = 720,
   parameter int MAX_FRAME_HEIGHT = 576
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // pixel_value[7:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,   // address, sample, zero pad
   output logic [2:0]                       rsp_tuser,   // plane[1:0], mb_last
   output logic                             rsp_tlast,   // frame_last
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mbr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mbr_pkg::MB_DIM_W-1:0]     csr_data
);
   import mbr_pkg::*;

   localparam int MB_DIM_MAX  = (1 << MB_DIM_W) - 1;
   localparam int W_MBS       = MAX_FRAME_WIDTH / 16;
   localparam int H_MBS       = MAX_FRAME_HEIGHT / 16;
   localparam int W_CLAMP     = (W_MBS < 1) ? 1 : ((W_MBS > MB_DIM_MAX) ? MB_DIM_MAX : W_MBS);
   localparam int H_CLAMP     = (H_MBS < 1) ? 1 : ((H_MBS > MB_DIM_MAX) ? MB_DIM_MAX : H_MBS);
   localparam logic [MB_DIM_W-1:0] W_LIMIT = MB_DIM_W'(W_CLAMP);
   localparam logic [MB_DIM_W-1:0] H_LIMIT = MB_DIM_W'(H_CLAMP);

   logic [MB_DIM_W-1:0] width_mbs_ff, width_mbs_in;
   logic [MB_DIM_W-1:0] height_mbs_ff, height_mbs_in;
   logic [MB_DIM_W-1:0] width_eff, height_eff;
   logic                csr_write, req_take;
   logic                s1_valid_ff, s1_valid_in, s1_ready;
   stage_type           s1_ff, s1_in;
   pos_type             cur_pos;
   result_type          rsp_word;

   // Size registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_mbs_in  = width_mbs_ff;
      height_mbs_in = height_mbs_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WIDTH_MBS:  width_mbs_in  = csr_data;
            CSR_HEIGHT_MBS: height_mbs_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_mbs_ff  <= WIDTH_MBS_RESET;
         height_mbs_ff <= HEIGHT_MBS_RESET;
      end else begin
         width_mbs_ff  <= width_mbs_in;
         height_mbs_ff <= height_mbs_in;
      end
   end

   // Clamp sizes to 1..frame limit
   assign width_eff  = (width_mbs_ff == '0) ? MB_DIM_W'(1) :
                       ((width_mbs_ff > W_LIMIT) ? W_LIMIT : width_mbs_ff);
   assign height_eff = (height_mbs_ff == '0) ? MB_DIM_W'(1) :
                       ((height_mbs_ff > H_LIMIT) ? H_LIMIT : height_mbs_ff);

   // Cursor advances on every accepted word
   assign req_tready = !s1_valid_ff || s1_ready;
   assign req_take   = req_tvalid && req_tready;

   mbr_cursor u_cursor (
      .clock      (clock),
      .reset      (reset),
      .step       (req_take),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .pos        (cur_pos)
   );

   // Decode stage register
   always_comb begin
      s1_in.pos    = cur_pos;
      s1_in.sample = req_tdata;
      s1_valid_in  = req_take || (s1_valid_ff && !s1_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
   end

   mbr_addr_stage u_addr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (s1_ready),
      .in_word   (s1_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_word)
   );

   assign rsp_tdata = {5'b00000, rsp_word.sample, rsp_word.address};
   assign rsp_tuser = {rsp_word.mb_last, rsp_word.plane};
   assign rsp_tlast = rsp_word.frame_last;

   // Frame end only lands on a macroblock end
   a_frame_on_mb: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[2])
      else $error("frame_last without mb_last");

   // Macroblock end is always a Cr sample
   a_mb_end_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == PLANE_V)
      else $error("mb_last on a non-Cr sample");

   // An accepted word always lands in the decode stage
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted word lost");

   // A blocked decode stage keeps its word
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_ready |=> s1_valid_ff && $stable(s1_ff))
      else $error("decode stage changed while stalled");

endmodule
